/* hdl/pmt_pkg.sv */
// pmt_pkg: shared types and constants of the program map table section parser
// no dependencies; compiled first
`default_nettype none

package pmt_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_ENTRY     = 2'd1,
    KIND_BAD_TABLE = 2'd2,
    KIND_TOO_MANY  = 2'd3
  } kind_t;

  // parser modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_HEADER = 3'd1,
    MODE_PINFO  = 3'd2,
    MODE_ENTRY  = 3'd3,
    MODE_ESSKIP = 3'd4
  } mode_t;

  localparam logic [7:0]  TABLE_ID_PMT      = 8'h02;
  localparam logic [7:0]  MAX_STREAMS_RESET = 8'd16;
  localparam logic [13:0] HEADER_TAIL_BYTES = 14'd13;  // header after length plus crc
  localparam logic [13:0] ENTRY_FIXED_BYTES = 14'd5;

  // header byte positions, counted from the table id byte
  localparam logic [3:0] HB_LEN_HI  = 4'd1;
  localparam logic [3:0] HB_LEN_LO  = 4'd2;
  localparam logic [3:0] HB_PROG_HI = 4'd3;
  localparam logic [3:0] HB_PROG_LO = 4'd4;
  localparam logic [3:0] HB_VERSION = 4'd5;
  localparam logic [3:0] HB_SEC_NUM = 4'd6;
  localparam logic [3:0] HB_LAST    = 4'd7;
  localparam logic [3:0] HB_PCR_HI  = 4'd8;
  localparam logic [3:0] HB_PCR_LO  = 4'd9;
  localparam logic [3:0] HB_INFO_HI = 4'd10;
  localparam logic [3:0] HB_INFO_LO = 4'd11;

  // entry byte positions
  localparam logic [3:0] EB_TYPE    = 4'd0;
  localparam logic [3:0] EB_PID_HI  = 4'd1;
  localparam logic [3:0] EB_PID_LO  = 4'd2;
  localparam logic [3:0] EB_INFO_HI = 4'd3;
  localparam logic [3:0] EB_INFO_LO = 4'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] table_length;
    logic [15:0] prog_num;
    logic [4:0]  version_number;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [12:0] pcr_pid;
    logic [11:0] program_info_length;
    logic [7:0]  es_type;
    logic [12:0] es_pid;
    logic [11:0] es_info_length;
  } result_t;

  // handshake between the stages
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* hdl/pmt_if.sv */
// pmt_if: valid/ready channel interfaces of the section parser
// no dependencies on the package; fields carried as plain vectors
`default_nettype none

interface pmt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;
  modport source (output valid, data_byte, section_start, input ready);
  modport sink   (input valid, data_byte, section_start, output ready);
endinterface

interface pmt_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] table_length;
  logic [15:0] prog_num;
  logic [4:0]  version_number;
  logic        current_next;
  logic [7:0]  sect_num;
  logic [7:0]  last_sect_num;
  logic [12:0] pcr_pid;
  logic [11:0] program_info_length;
  logic [7:0]  es_type;
  logic [12:0] es_pid;
  logic [11:0] es_info_length;
  modport source (output valid, kind, table_length, prog_num, version_number,
                  current_next, sect_num, last_sect_num, pcr_pid,
                  program_info_length, es_type, es_pid, es_info_length,
                  input ready);
  modport sink   (input valid, kind, table_length, prog_num, version_number,
                  current_next, sect_num, last_sect_num, pcr_pid,
                  program_info_length, es_type, es_pid, es_info_length,
                  output ready);
endinterface

interface pmt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_streams;
  modport source (output valid, max_streams, input ready);
  modport sink   (input valid, max_streams, output ready);
endinterface

`default_nettype wire

/* hdl/pmt_section_parser.sv */
// pmt_section_parser: top level of the program map table section parser
// depends on pmt_pkg, pmt_if, pmt_in_stage, pmt_parse_core, pmt_out_stage
//
//   channel   dir   payload                                     transaction
//   section   in    data_byte, section_start                    one section byte
//   result    out   kind, header fields, entry fields           one parse result
//   cfg       in    max_streams                                 register write
//
// one byte per cycle sustained while the result side is free; a byte is held in the input register,
// is decoded by the parse core and its result is registered in the result register,
// from which the result transaction is made
// the result register is the only point of backpressure: while it holds an
// untaken result the input register stalls, and section.ready follows it
// synchronous reset clears the valids and returns the parser to idle with
// max_streams at 16; cfg is always ready
`default_nettype none

module pmt_section_parser (
  input wire logic     clk,
  input wire logic     rst,
  pmt_byte_if.sink     section,
  pmt_result_if.source result,
  pmt_cfg_if.sink      cfg
);
  import pmt_pkg::*;

  in_item_t   in_item;
  in_item_t   s1_item;
  stage_ctl_t s1_ctl;
  stage_ctl_t core_ctl;
  logic       out_free;
  logic       res_fire;
  result_t    res_next;
  result_t    res_q;

  // the user must write the register only while the parser is idle; the block itself does not enforce it
  assign cfg.ready = 1'b1;

  assign in_item.data_byte     = section.data_byte;
  assign in_item.section_start = section.section_start;

  // input register: holds one accepted byte until the result side can move
  pmt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (section.valid),
    .in_ready (section.ready),
    .in_item  (in_item),
    .ctl_out  (s1_ctl),
    .advance  (out_free),
    .item     (s1_item)
  );

  assign core_ctl = s1_ctl;

  // decode of the held byte against the parse state
  pmt_parse_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg.valid & cfg.ready),
    .cfg_max_streams (cfg.max_streams),
    .ctl             (core_ctl),
    .item            (s1_item),
    .res_fire        (res_fire),
    .res             (res_next)
  );

  // result register toward the consumer
  pmt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_fire  (res_fire),
    .res_in    (res_next),
    .free      (out_free),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res_out   (res_q)
  );

  assign result.kind                = res_q.kind;
  assign result.table_length        = res_q.table_length;
  assign result.prog_num            = res_q.prog_num;
  assign result.version_number      = res_q.version_number;
  assign result.current_next        = res_q.current_next;
  assign result.sect_num            = res_q.sect_num;
  assign result.last_sect_num       = res_q.last_sect_num;
  assign result.pcr_pid             = res_q.pcr_pid;
  assign result.program_info_length = res_q.program_info_length;
  assign result.es_type             = res_q.es_type;
  assign result.es_pid              = res_q.es_pid;
  assign result.es_info_length      = res_q.es_info_length;

endmodule

`default_nettype wire

/* hdl/pmt_in_stage.sv */
// pmt_in_stage: input register holding one accepted section byte
// depends on pmt_pkg
`default_nettype none

module pmt_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pmt_pkg::in_item_t in_item,
  output pmt_pkg::stage_ctl_t    ctl_out,  // valid and take of the held byte
  input  wire logic              advance,
  output pmt_pkg::in_item_t      item
);
  import pmt_pkg::*;

  logic held;
  logic take;

  assign take           = held & advance;
  assign in_ready       = ~held | advance;
  assign ctl_out.valid  = held;
  assign ctl_out.take   = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/pmt_parse_core.sv */
// pmt_parse_core: parse state, held header fields and per-byte decode
// depends on pmt_pkg
`default_nettype none

module pmt_parse_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [7:0]          cfg_max_streams,
  input  wire pmt_pkg::stage_ctl_t ctl,
  input  wire pmt_pkg::in_item_t   item,
  output logic                     res_fire,
  output pmt_pkg::result_t         res
);
  import pmt_pkg::*;

  mode_t       mode, mode_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [7:0]  max_streams;
  logic [11:0] length_held, length_held_next;
  logic [11:0] info_length_held, info_length_held_next;
  logic [11:0] skip_remaining, skip_remaining_next;
  logic [13:0] consumed_count, consumed_count_next;
  logic [7:0]  entry_count, entry_count_next;
  logic [15:0] prog_num, prog_num_next;
  logic [4:0]  version_number, version_number_next;
  logic        current_next, current_next_next;
  logic [7:0]  sect_num, sect_num_next;
  logic [7:0]  last_sect_num, last_sect_num_next;
  logic [12:0] pcr_pid, pcr_pid_next;
  logic [7:0]  es_type, es_type_next;
  logic [12:0] es_pid, es_pid_next;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_streams <= MAX_STREAMS_RESET;
    end else if (cfg_write) begin
      max_streams <= cfg_max_streams;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      byte_index <= '0;
    end else begin
      mode <= mode_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    length_held         <= length_held_next;
    info_length_held    <= info_length_held_next;
    skip_remaining      <= skip_remaining_next;
    consumed_count      <= consumed_count_next;
    entry_count         <= entry_count_next;
    prog_num            <= prog_num_next;
    version_number      <= version_number_next;
    current_next        <= current_next_next;
    sect_num            <= sect_num_next;
    last_sect_num       <= last_sect_num_next;
    pcr_pid             <= pcr_pid_next;
    es_type             <= es_type_next;
    es_pid              <= es_pid_next;
  end

  always_comb begin
    mode_next                = mode;
    byte_index_next          = byte_index;
    length_held_next         = length_held;
    info_length_held_next    = info_length_held;
    skip_remaining_next      = skip_remaining;
    consumed_count_next      = consumed_count;
    entry_count_next         = entry_count;
    prog_num_next            = prog_num;
    version_number_next      = version_number;
    current_next_next        = current_next;
    sect_num_next            = sect_num;
    last_sect_num_next       = last_sect_num;
    pcr_pid_next             = pcr_pid;
    es_type_next             = es_type;
    es_pid_next              = es_pid;
    res_fire                 = 1'b0;
    res                      = '0;

    if (ctl.take) begin
      if (item.section_start) begin
        if (b != TABLE_ID_PMT) begin
          mode_next = MODE_IDLE;
          res_fire  = 1'b1;
          res.kind  = KIND_BAD_TABLE;
        end else begin
          mode_next           = MODE_HEADER;
          byte_index_next     = HB_LEN_HI;
          consumed_count_next = '0;
          entry_count_next    = '0;
        end
      end else begin
        case (mode)
          MODE_HEADER: begin
            byte_index_next = byte_index + 4'd1;
            case (byte_index)
              HB_LEN_HI:  length_held_next = {b[3:0], 8'h00};
              HB_LEN_LO:  length_held_next = {length_held[11:8], b};
              HB_PROG_HI: prog_num_next = {b, 8'h00};
              HB_PROG_LO: prog_num_next = {prog_num[15:8], b};
              HB_VERSION: begin
                version_number_next = b[5:1];
                current_next_next   = b[0];
              end
              HB_SEC_NUM: sect_num_next = b;
              HB_LAST:    last_sect_num_next = b;
              HB_PCR_HI:  pcr_pid_next = {b[4:0], 8'h00};
              HB_PCR_LO:  pcr_pid_next = {pcr_pid[12:8], b};
              HB_INFO_HI: info_length_held_next = {b[3:0], 8'h00};
              default: begin
                // last header byte: emit header, then skip the program info if any, else go on to entries or idle
                info_length_held_next = {info_length_held[11:8], b};
                consumed_count_next   = {2'b00, info_length_held_next} + HEADER_TAIL_BYTES;
                res_fire              = 1'b1;
                res.kind              = KIND_HEADER;
                if (info_length_held_next != 12'd0) begin
                  mode_next           = MODE_PINFO;
                  skip_remaining_next = info_length_held_next;
                end else if (consumed_count_next < {2'b00, length_held}) begin
                  mode_next       = MODE_ENTRY;
                  byte_index_next = EB_TYPE;
                end else begin
                  mode_next = MODE_IDLE;
                end
              end
            endcase
          end
          MODE_PINFO, MODE_ESSKIP: begin
            skip_remaining_next = skip_remaining - 12'd1;
            if (skip_remaining_next == 12'd0) begin
              if (consumed_count < {2'b00, length_held}) begin
                mode_next       = MODE_ENTRY;
                byte_index_next = EB_TYPE;
              end else begin
                mode_next = MODE_IDLE;
              end
            end
          end
          MODE_ENTRY: begin
            byte_index_next = byte_index + 4'd1;
            case (byte_index)
              EB_TYPE: begin
                if (entry_count >= max_streams) begin
                  mode_next = MODE_IDLE;
                  res_fire  = 1'b1;
                  res.kind  = KIND_TOO_MANY;
                end else begin
                  es_type_next = b;
                end
              end
              EB_PID_HI:  es_pid_next = {b[4:0], 8'h00};
              EB_PID_LO:  es_pid_next = {es_pid[12:8], b};
              EB_INFO_HI: skip_remaining_next = {b[3:0], 8'h00};
              default: begin
                skip_remaining_next = {skip_remaining[11:8], b};
                res_fire            = 1'b1;
                res.kind            = KIND_ENTRY;
                res.es_type         = es_type;
                res.es_pid          = es_pid;
                res.es_info_length  = skip_remaining_next;
                consumed_count_next = consumed_count + ENTRY_FIXED_BYTES
                                      + {2'b00, skip_remaining_next};
                entry_count_next    = entry_count + 8'd1;
                if (skip_remaining_next != 12'd0) begin
                  mode_next = MODE_ESSKIP;
                end else if (consumed_count_next < {2'b00, length_held}) begin
                  mode_next       = MODE_ENTRY;
                  byte_index_next = EB_TYPE;
                end else begin
                  mode_next = MODE_IDLE;
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end

      // header, entry and too-many results carry the held header
      if (res_fire && (res.kind != KIND_BAD_TABLE)) begin
        res.table_length        = length_held;
        res.prog_num            = prog_num;
        res.version_number      = version_number;
        res.current_next        = current_next;
        res.sect_num            = sect_num;
        res.last_sect_num       = last_sect_num;
        res.pcr_pid             = pcr_pid;
        res.program_info_length = info_length_held_next;
      end
    end
  end

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> ctl.valid) else $error("byte taken from an empty input register");

  a_fire_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> ctl.take) else $error("result raised without a taken byte");

  a_bad_table_idles: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && item.section_start && (b != TABLE_ID_PMT)) |=> (mode == MODE_IDLE))
    else $error("wrong table id did not return to idle");

  a_header_index: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEADER) |-> ((byte_index >= HB_LEN_HI) && (byte_index <= HB_INFO_LO)))
    else $error("header byte index out of range");

  a_entry_index: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ENTRY) |-> (byte_index <= EB_INFO_LO))
    else $error("entry byte index out of range");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_PINFO) || (mode == MODE_ESSKIP)) |-> (skip_remaining != 12'd0))
    else $error("skipping with nothing left to skip");

endmodule

`default_nettype wire

/* hdl/pmt_out_stage.sv */
// pmt_out_stage: result register with valid/ready toward the consumer
// depends on pmt_pkg
`default_nettype none

module pmt_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_fire,
  input  wire pmt_pkg::result_t res_in,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pmt_pkg::result_t      res_out
);
  import pmt_pkg::*;

  assign free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_fire) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_pmt_section_parser.sv */
// tb_pmt_section_parser: self-checking testbench of the program map table section parser
// depends on pmt_pkg, pmt_if and the pmt_section_parser rtl; a behavioral predictor in
// this file works out every result, which is checked field by field against the dut
`timescale 1ns / 100ps

module tb_pmt_section_parser;
  import pmt_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;  // many times the slowest correct run
  localparam int PHASE_ITEMS      = 420;     // section bytes per random phase
  localparam int HOLD_OFF_CYCLES  = 300;     // long result stall to back up the input
  localparam int DRAIN_LIMIT      = 2000;    // wait for results once all bytes are in
  localparam int SETTLE_CYCLES    = 6;       // lets the input and result registers settle
  localparam int REPORT_LINES_MAX = 40;
  localparam int LONG_CUT_BYTES   = 40;      // body bytes kept of a very long cut section

  // how the declared section length relates to the bytes that follow
  localparam int LEN_EXACT  = 0;
  localparam int LEN_SHORT  = 1;
  localparam int LEN_RANDOM = 2;

  logic clk = 1'b0;
  logic rst;

  pmt_byte_if   section_ch ();
  pmt_result_if result_ch ();
  pmt_cfg_if    cfg_ch ();

  pmt_section_parser dut (
    .clk     (clk),
    .rst     (rst),
    .section (section_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shared state of stimulus, predictor and checker
  // ---------------------------------------------------------------------------
  in_item_t byte_backlog [$];      // section bytes waiting to be offered
  result_t  awaited_results [$];   // predicted results, oldest first
  int       bytes_queued = 0;
  int       body_budget;           // cuts a section short when a restart is wanted
  int       mismatch_count = 0;
  int       kind_tally [4] = '{0, 0, 0, 0};
  int       bytes_taken = 0;

  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  bit       hold_off_req = 1'b0;
  int       hold_off_count = 0;
  int       cycle_count = 0;

  bit       byte_taken;            // set at the rising edge, read by the driver
  in_item_t offer_item;
  result_t  seen_result;

  // predictor copy of the parser state
  mode_t       parse_state = MODE_IDLE;
  logic [3:0]  field_pos = '0;
  result_t     held_header = '0;   // header fields of the current section, entry fields 0
  logic [11:0] skip_left = '0;
  logic [13:0] consumed_len = '0;
  logic [7:0]  stream_count = '0;
  logic [7:0]  stream_limit = MAX_STREAMS_RESET;
  logic [7:0]  entry_type = '0;
  logic [12:0] entry_pid = '0;

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got_val,
                                 input longint want_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES_MAX)
      $display("mismatch %0d at %0t: %s got %0d want %0d", mismatch_count, $time, what,
               got_val, want_val);
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // after the header, the program info or an entry: more entries while the
  // running length stays below the declared section length
  task automatic next_entry_or_idle();
    if (consumed_len < {2'b00, held_header.table_length}) begin
      parse_state = MODE_ENTRY;
      field_pos = EB_TYPE;
    end else begin
      parse_state = MODE_IDLE;
    end
  endtask

  task automatic parse_section_byte(input logic [7:0] b, input logic first);
    result_t res;
    bit      field_done;
    res = '0;
    field_done = 1'b0;
    if (first) begin
      // a start flag restarts parsing wherever the previous section was
      if (b != TABLE_ID_PMT) begin
        parse_state = MODE_IDLE;
        res.kind = KIND_BAD_TABLE;
        awaited_results.push_back(res);
      end else begin
        parse_state = MODE_HEADER;
        field_pos = HB_LEN_HI;
        held_header = '0;
        skip_left = '0;
        consumed_len = '0;
        stream_count = '0;
        entry_type = '0;
        entry_pid = '0;
      end
    end else begin
      case (parse_state)
        MODE_HEADER: begin
          case (field_pos)
            HB_LEN_HI:  held_header.table_length = {b[3:0], 8'h00};
            HB_LEN_LO:  held_header.table_length[7:0] = b;
            HB_PROG_HI: held_header.prog_num[15:8] = b;
            HB_PROG_LO: held_header.prog_num[7:0] = b;
            HB_VERSION: begin
              held_header.version_number = b[5:1];
              held_header.current_next = b[0];
            end
            HB_SEC_NUM: held_header.sect_num = b;
            HB_LAST:    held_header.last_sect_num = b;
            HB_PCR_HI:  held_header.pcr_pid[12:8] = b[4:0];
            HB_PCR_LO:  held_header.pcr_pid[7:0] = b;
            HB_INFO_HI: held_header.program_info_length = {b[3:0], 8'h00};
            default: begin
              // last header byte: the header result goes out here
              held_header.program_info_length[7:0] = b;
              consumed_len = {2'b00, held_header.program_info_length} + HEADER_TAIL_BYTES;
              res = held_header;
              res.kind = KIND_HEADER;
              awaited_results.push_back(res);
              if (held_header.program_info_length != 0) begin
                parse_state = MODE_PINFO;
                skip_left = held_header.program_info_length;
              end else begin
                next_entry_or_idle();
              end
              field_done = 1'b1;
            end
          endcase
          if (!field_done) field_pos = field_pos + 4'd1;
        end

        MODE_ENTRY: begin
          case (field_pos)
            EB_TYPE: begin
              if (stream_count >= stream_limit) begin
                parse_state = MODE_IDLE;
                res = held_header;
                res.kind = KIND_TOO_MANY;
                awaited_results.push_back(res);
                field_done = 1'b1;
              end else begin
                entry_type = b;
              end
            end
            EB_PID_HI:  entry_pid = {b[4:0], 8'h00};
            EB_PID_LO:  entry_pid[7:0] = b;
            EB_INFO_HI: skip_left = {b[3:0], 8'h00};
            default: begin
              skip_left[7:0] = b;
              res = held_header;
              res.kind = KIND_ENTRY;
              res.es_type = entry_type;
              res.es_pid = entry_pid;
              res.es_info_length = skip_left;
              awaited_results.push_back(res);
              consumed_len = consumed_len + ENTRY_FIXED_BYTES + {2'b00, skip_left};
              stream_count = stream_count + 8'd1;
              if (skip_left != 0) parse_state = MODE_ESSKIP;
              else next_entry_or_idle();
              field_done = 1'b1;
            end
          endcase
          if (!field_done) field_pos = field_pos + 4'd1;
        end

        MODE_PINFO, MODE_ESSKIP: begin
          skip_left = skip_left - 12'd1;
          if (skip_left == 0) next_entry_or_idle();
        end

        default: ;  // idle: stray bytes are dropped
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------
  task automatic check_result(input result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited, kind", got.kind, -1);
      return;
    end
    want = awaited_results.pop_front();
    kind_tally[want.kind]++;
    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.table_length != want.table_length)
      report_mismatch("table_length", got.table_length, want.table_length);
    if (got.prog_num != want.prog_num)
      report_mismatch("prog_num", got.prog_num, want.prog_num);
    if (got.version_number != want.version_number)
      report_mismatch("version_number", got.version_number, want.version_number);
    if (got.current_next != want.current_next)
      report_mismatch("current_next", got.current_next, want.current_next);
    if (got.sect_num != want.sect_num)
      report_mismatch("sect_num", got.sect_num, want.sect_num);
    if (got.last_sect_num != want.last_sect_num)
      report_mismatch("last_sect_num", got.last_sect_num, want.last_sect_num);
    if (got.pcr_pid != want.pcr_pid) report_mismatch("pcr_pid", got.pcr_pid, want.pcr_pid);
    if (got.program_info_length != want.program_info_length)
      report_mismatch("program_info_length", got.program_info_length,
                      want.program_info_length);
    if (got.es_type != want.es_type)
      report_mismatch("es_type", got.es_type, want.es_type);
    if (got.es_pid != want.es_pid)
      report_mismatch("es_pid", got.es_pid, want.es_pid);
    if (got.es_info_length != want.es_info_length)
      report_mismatch("es_info_length", got.es_info_length, want.es_info_length);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge, before the dut updates
  // results are checked before the byte of the same edge is predicted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_taken = section_ch.valid && section_ch.ready;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        seen_result.kind                = kind_t'(result_ch.kind);
        seen_result.table_length        = result_ch.table_length;
        seen_result.prog_num            = result_ch.prog_num;
        seen_result.version_number      = result_ch.version_number;
        seen_result.current_next        = result_ch.current_next;
        seen_result.sect_num            = result_ch.sect_num;
        seen_result.last_sect_num       = result_ch.last_sect_num;
        seen_result.pcr_pid             = result_ch.pcr_pid;
        seen_result.program_info_length = result_ch.program_info_length;
        seen_result.es_type             = result_ch.es_type;
        seen_result.es_pid              = result_ch.es_pid;
        seen_result.es_info_length      = result_ch.es_info_length;
        check_result(seen_result);
      end
      if (byte_taken) begin
        bytes_taken++;
        parse_section_byte(section_ch.data_byte, section_ch.section_start);
      end
      // register transaction: takes effect for the bytes that follow
      if (cfg_ch.valid && cfg_ch.ready) stream_limit = cfg_ch.max_streams;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers the next byte at the falling edge once the previous
  // transaction has completed, idling at random per the current phase
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      section_ch.valid <= 1'b0;
    end else if (!section_ch.valid || byte_taken) begin
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        offer_item = byte_backlog.pop_front();
        section_ch.valid         <= 1'b1;
        section_ch.data_byte     <= offer_item.data_byte;
        section_ch.section_start <= offer_item.section_start;
      end else begin
        section_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, or one long hold-off while bytes keep coming
  always @(negedge clk) begin
    if (hold_off_req && hold_off_count < HOLD_OFF_CYCLES) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // length of the hold-off, counted on its own
  always @(posedge clk) begin
    if (hold_off_req && hold_off_count < HOLD_OFF_CYCLES) hold_off_count <= hold_off_count + 1;
  end

  // cycle limit on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_byte(input int b, input bit first);
    in_item_t item;
    item.data_byte = b[7:0];
    item.section_start = first;
    byte_backlog.push_back(item);
    bytes_queued++;
  endtask

  // body byte of a section; dropped once a cut section has used its budget
  task automatic push_body(input int b);
    if (body_budget > 0) begin
      push_byte(b, 1'b0);
      body_budget--;
    end
  endtask

  // zero and all ones turn up often, otherwise any value of the width
  function automatic int pick_field(input int bits);
    int mask;
    mask = (1 << bits) - 1;
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // one section: header, program info, entries and crc, with random reserved bits;
  // descriptor limits above 64 are used as the exact length, and a very long
  // section that is cut keeps only a short fixed run of body bytes
  task automatic queue_section(input int info_len, input int n_entries, input int es_limit,
                               input int length_style, input bit cut);
    int es_len [$];
    int full_len, sect_len, es, pid, pcr, ver, i;
    full_len = 13 + info_len;
    for (i = 0; i < n_entries; i++) begin
      if (es_limit > 64) es = es_limit;
      else es = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, es_limit);
      es_len.push_back(es);
      full_len += 5 + es;
    end
    case (length_style)
      LEN_SHORT:  sect_len = full_len - $urandom_range(1, 6);
      LEN_RANDOM: sect_len = $urandom_range(0, full_len + 16);
      default:    sect_len = full_len;
    endcase
    if (sect_len > 4095) sect_len = 4095;
    if (sect_len < 0) sect_len = 0;
    if (!cut) body_budget = 32'h7fff_ffff;
    else if (full_len > 200) body_budget = LONG_CUT_BYTES;
    else body_budget = $urandom_range(1, full_len);

    pcr = pick_field(13);
    ver = pick_field(5);
    push_byte(TABLE_ID_PMT, 1'b1);
    push_body(($urandom & 'hF0) | ((sect_len >> 8) & 'h0F));
    push_body(sect_len & 'hFF);
    push_body(pick_field(8));                                   // program number
    push_body(pick_field(8));
    push_body(($urandom & 'hC0) | (ver << 1) | $urandom_range(0, 1));
    push_body(pick_field(8));                                   // section number
    push_body(pick_field(8));                                   // last section number
    push_body(($urandom & 'hE0) | (pcr >> 8));
    push_body(pcr & 'hFF);
    push_body(($urandom & 'hF0) | ((info_len >> 8) & 'h0F));
    push_body(info_len & 'hFF);
    repeat (info_len) push_body($urandom);
    for (i = 0; i < n_entries; i++) begin
      pid = pick_field(13);
      push_body(pick_field(8));                                 // stream type
      push_body(($urandom & 'hE0) | (pid >> 8));
      push_body(pid & 'hFF);
      push_body(($urandom & 'hF0) | ((es_len[i] >> 8) & 'h0F));
      push_body(es_len[i] & 'hFF);
      repeat (es_len[i]) push_body($urandom);
    end
    repeat (4) push_body($urandom);                             // crc, never checked
  endtask

  // mostly well-formed sections with random content; some with a wrong
  // length, some cut short by the next start, plus wrong ids and stray bytes
  task automatic queue_random_section();
    int roll, b;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      b = $urandom_range(0, 255);
      if (b == TABLE_ID_PMT) b = 'hFF;
      push_byte(b, 1'b1);
      repeat ($urandom_range(0, 3)) push_byte($urandom, 1'b0);
    end else if (roll < 9) begin
      repeat ($urandom_range(1, 4)) push_byte($urandom, 1'b0);
    end else begin
      queue_section(($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3),
                    $urandom_range(0, 5), 6,
                    (roll < 15) ? LEN_SHORT : ((roll < 21) ? LEN_RANDOM : LEN_EXACT),
                    $urandom_range(0, 11) == 0);
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) push_byte($urandom, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------------------
  task automatic write_max_streams(input logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_streams <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // all bytes taken, then the awaited results (bounded), then pipeline settle
  task automatic wait_for_quiet();
    int waited;
    waited = 0;
    while (byte_backlog.size() != 0 || section_ch.valid) @(posedge clk);
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [7:0] limit, input bit hold_off,
                                  input bit oversize);
    int start_count;
    write_max_streams(limit);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    if (hold_off) hold_off_req = 1'b1;
    @(posedge clk);
    start_count = bytes_queued;
    while (bytes_queued - start_count < PHASE_ITEMS) queue_random_section();
    if (oversize) begin
      // largest program info length, then one entry with the largest
      // descriptor length, each cut short after a few dozen body bytes
      queue_section(4095, 0, 0, LEN_EXACT, 1'b1);
      queue_section(0, 1, 4095, LEN_EXACT, 1'b1);
    end
    wait_for_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] mixed_limit;
    rst = 1'b1;
    section_ch.valid = 1'b0;
    section_ch.data_byte = '0;
    section_ch.section_start = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_streams = '0;
    mixed_limit = 8'($urandom_range(2, 8));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one entry allowed per section
    write_max_streams(8'd1);
    @(posedge clk);
    push_byte('h5A, 1'b0);                                      // stray byte while idle
    push_byte('hFD, 1'b1);                                      // wrong table id
    // header with every field at its top value, length 23, no program info
    push_byte(TABLE_ID_PMT, 1'b1);
    push_byte('hF0, 1'b0); push_byte('h17, 1'b0);
    push_byte('hFF, 1'b0); push_byte('hFF, 1'b0); push_byte('hFF, 1'b0);
    push_byte('hFF, 1'b0); push_byte('hFF, 1'b0); push_byte('hFF, 1'b0);
    push_byte('hFF, 1'b0); push_byte('hF0, 1'b0); push_byte('h00, 1'b0);
    // one entry at the top values with no descriptors, then a second one over the limit
    push_byte('hFF, 1'b0); push_byte('hFF, 1'b0); push_byte('hFF, 1'b0);
    push_byte('hF0, 1'b0); push_byte('h00, 1'b0);
    push_byte('h00, 1'b0);
    // header left part way; the bytes of the next phase continue it or restart parsing
    push_byte(TABLE_ID_PMT, 1'b1);
    push_byte('h0F, 1'b0); push_byte('hFF, 1'b0); push_byte('h00, 1'b0);
    wait_for_quiet();

    run_random_phase(0, 0, MAX_STREAMS_RESET, 1'b1, 1'b0);
    run_random_phase(48, 0, 8'd255, 1'b0, 1'b1);
    run_random_phase(0, 48, 8'd1, 1'b0, 1'b0);
    run_random_phase(24, 24, mixed_limit, 1'b0, 1'b0);

    if (awaited_results.size() != 0)
      report_mismatch("results never delivered, count", 0, awaited_results.size());

    $display("covered %0d section bytes and %0d results: %0d headers, %0d entries, %0d bad ids,",
             bytes_taken, kind_tally[0] + kind_tally[1] + kind_tally[2] + kind_tally[3],
             kind_tally[KIND_HEADER], kind_tally[KIND_ENTRY], kind_tally[KIND_BAD_TABLE]);
    $display("%0d over the entry limit; max_streams 1, 16, 255, 1, %0d; %0d cycle hold-off",
             kind_tally[KIND_TOO_MANY], mixed_limit, hold_off_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* pmt_section_parser.f */
hdl/pmt_pkg.sv
hdl/pmt_if.sv
hdl/pmt_in_stage.sv
hdl/pmt_parse_core.sv
hdl/pmt_out_stage.sv
hdl/pmt_section_parser.sv
verif/tb_pmt_section_parser.sv
